@@ rtl/scbp_pkg.sv @@
// shared types and constants of the size class buffer pool
`default_nettype none

package scbp_pkg;

  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned CLS_W       = 2;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned USE_W       = 11;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0] SMALL_LIMIT_RST  = 16'd64;
  localparam logic [CFG_W-1:0] MEDIUM_LIMIT_RST = 16'd128;
  localparam logic [CFG_W-1:0] LARGE_LIMIT_RST  = 16'd256;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_SUPER  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_NOT_IN_USE  = 2'd2
  } status_e;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [CLS_W-1:0]  release_class;
    logic [IDX_W-1:0]  release_index;
  } scbp_req_t;

  typedef struct packed {
    status_e           status;
    logic [CLS_W-1:0]  granted_class;
    logic [IDX_W-1:0]  granted_index;
    logic [USE_W-1:0]  class_in_use;
  } scbp_rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic read;
    logic exec;
  } scbp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/scbp_ctrl.sv @@
// controller state machine of the size class buffer pool
`default_nettype none

module scbp_ctrl
  import scbp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output scbp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_READ;
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.read = (state_q == S_READ);
  assign cmd_o.exec = (state_q == S_EXEC);

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 cmd_o.exec) else $error("accepted transaction did not reach exec");
  a_exec_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !busy) else $error("busy after exec");
  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.read, cmd_o.exec})) else $error("overlapping commands");
`endif

endmodule

`default_nettype wire

@@ rtl/scbp_datapath.sv @@
// datapath: limits, class pick, free stacks, busy flags and result register
`default_nettype none

module scbp_datapath
  import scbp_pkg::*;
#(
  parameter int unsigned BUFS_PER_CLASS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire scbp_cmd_t            cmd_i,
  input  wire scbp_req_t            req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output scbp_rsp_t                 rsp_o,
  output logic                      rsp_valid_o
);

  localparam int unsigned PW    = $clog2(BUFS_PER_CLASS);
  localparam int unsigned TW    = $clog2(BUFS_PER_CLASS + 1);
  localparam int unsigned CW    = (TW > IDX_W) ? TW : IDX_W;
  localparam int unsigned UW    = (TW > USE_W) ? TW : USE_W;
  localparam int unsigned AW    = CLS_W + PW;
  localparam int unsigned MEM_D = 2 ** AW;
  localparam logic [TW-1:0] BUFS_T = TW'(BUFS_PER_CLASS);
  localparam logic [CW-1:0] BUFS_C = CW'(BUFS_PER_CLASS);
  localparam logic [UW-1:0] BUFS_U = UW'(BUFS_PER_CLASS);

  logic [CFG_W-1:0] small_q, medium_q, large_q;
  scbp_req_t        req_q;
  logic [CLS_W-1:0] cls_q, cls_d;

  // free count per class, and the lowest it has ever been
  logic [TW-1:0] top_q [NUM_CLASSES];
  logic [TW-1:0] top_d [NUM_CLASSES];
  logic [TW-1:0] low_q [NUM_CLASSES];
  logic [TW-1:0] low_d [NUM_CLASSES];

  logic [PW-1:0] stack_mem [MEM_D];
  logic          busy_mem  [MEM_D];
  logic [PW-1:0] stk_rd_q;
  logic          bsy_rd_q;

  scbp_rsp_t rsp_q, rsp_d;
  logic      rsp_valid_q;

  logic [TW-1:0] top_cur, low_cur, pos_pop, new_top;
  logic [CW-1:0] ridx_ext;
  logic [PW-1:0] ridx_pw, pop_idx;
  logic          busy_eff;
  logic [UW-1:0] use_wide;
  logic          bw_en, bw_val, sw_en;
  logic [AW-1:0] bw_addr, sw_addr, stk_raddr, bsy_raddr;

  // class pick in limit order, or the release class on a free
  always_comb begin
    if (req_i.action == ACT_FREE) begin
      cls_d = req_i.release_class;
    end else if (req_i.request_size > large_q) begin
      cls_d = CLS_SUPER;
    end else if (req_i.request_size > medium_q) begin
      cls_d = CLS_LARGE;
    end else if (req_i.request_size > small_q) begin
      cls_d = CLS_MEDIUM;
    end else begin
      cls_d = CLS_SMALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q  <= SMALL_LIMIT_RST;
      medium_q <= MEDIUM_LIMIT_RST;
      large_q  <= LARGE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SMALL_LIMIT:  small_q  <= cfg_data_i;
        CFG_MEDIUM_LIMIT: medium_q <= cfg_data_i;
        CFG_LARGE_LIMIT:  large_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      cls_q <= cls_d;
    end
  end

  assign top_cur  = top_q[cls_q];
  assign low_cur  = low_q[cls_q];
  assign pos_pop  = top_cur - TW'(1);
  assign ridx_ext = CW'(req_q.release_index);
  assign ridx_pw  = PW'(ridx_ext);

  // entries below the low mark were never written and still hold their position
  assign pop_idx  = (pos_pop < low_cur) ? pos_pop[PW-1:0] : stk_rd_q;
  // an index below the low mark was never handed out
  assign busy_eff = (ridx_ext >= CW'(low_cur)) && bsy_rd_q;

  assign stk_raddr = {cls_q, pos_pop[PW-1:0]};
  assign bsy_raddr = {cls_q, ridx_pw};

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      top_d[c] = top_q[c];
      low_d[c] = low_q[c];
    end
    new_top = top_cur;
    bw_en   = 1'b0;
    bw_val  = 1'b0;
    bw_addr = {cls_q, pop_idx};
    sw_en   = 1'b0;
    sw_addr = {cls_q, top_cur[PW-1:0]};
    rsp_d.status        = ST_OK;
    rsp_d.granted_class = cls_q;
    rsp_d.granted_index = '0;
    if (req_q.action == ACT_ALLOC) begin
      if (top_cur == '0) begin
        rsp_d.status = ST_EXHAUSTED;
      end else begin
        new_top = pos_pop;
        top_d[cls_q] = pos_pop;
        if (pos_pop < low_cur) low_d[cls_q] = pos_pop;
        bw_en  = cmd_i.exec;
        bw_val = 1'b1;
        rsp_d.granted_index = IDX_W'(pop_idx);
      end
    end else begin
      if ((ridx_ext >= BUFS_C) || !busy_eff || (top_cur >= BUFS_T)) begin
        rsp_d.status = ST_NOT_IN_USE;
      end else begin
        new_top = top_cur + TW'(1);
        top_d[cls_q] = new_top;
        bw_en   = cmd_i.exec;
        bw_val  = 1'b0;
        bw_addr = {cls_q, ridx_pw};
        sw_en   = cmd_i.exec;
        rsp_d.granted_index = req_q.release_index;
      end
    end
    use_wide = BUFS_U - UW'(new_top);
    rsp_d.class_in_use = use_wide[USE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        top_q[c] <= BUFS_T;
        low_q[c] <= BUFS_T;
      end
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          top_q[c] <= top_d[c];
          low_q[c] <= low_d[c];
        end
      end
      rsp_valid_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  // stack and busy memories, one read and one write port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      stk_rd_q <= stack_mem[stk_raddr];
      bsy_rd_q <= busy_mem[bsy_raddr];
    end
    if (sw_en) stack_mem[sw_addr] <= ridx_pw;
    if (bw_en) busy_mem[bw_addr] <= bw_val;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

`ifndef ASSERT_OFF
  a_rsp_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q == $past(cmd_i.exec)) else $error("result strobe not tied to exec");
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q[0] <= BUFS_T) && (top_q[1] <= BUFS_T) &&
    (top_q[2] <= BUFS_T) && (top_q[3] <= BUFS_T)) else $error("free count overflow");
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q[0] <= top_q[0]) && (low_q[1] <= top_q[1]) &&
    (low_q[2] <= top_q[2]) && (low_q[3] <= top_q[3])) else $error("low mark above top");
`endif

endmodule

`default_nettype wire

@@ rtl/size_class_buffer_pool.sv @@
// top level of the size class buffer pool: controller plus datapath
// sequence: an accepted transaction passes the read and exec states, and its result strobe is registered in exec
// a new transaction is taken only in idle, after the registered read of the stack and
//   busy memories and the write-back in exec; busy is high in the read and exec states
// reset: asynchronous, active low; limits return to 64/128/256 and every class is full at once
// the receiver cannot stall: rsp_valid_o marks each result for exactly one cycle
`default_nettype none

module size_class_buffer_pool
  import scbp_pkg::*;
#(
  parameter int unsigned BUFS_PER_CLASS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request transaction
  input  wire logic                 start,
  output logic                      busy,
  input  wire scbp_req_t            req_i,
  // result transaction
  output logic                      rsp_valid_o,
  output scbp_rsp_t                 rsp_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // load, read and exec steps from the controller
  scbp_cmd_t cmd;

  // sequencer: idle, memory read, and exec with write-back
  scbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // limits, class pick, free stacks with low marks, busy flags
  scbp_datapath #(
    .BUFS_PER_CLASS (BUFS_PER_CLASS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

`default_nettype wire

@@ tb/pool_checker.sv @@
// checker for the size class buffer pool: tracks the free lists and compares every result
`timescale 1ns / 100ps

module pool_checker
  import scbp_pkg::*;
#(
  parameter int unsigned BUFS_PER_CLASS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  scbp_req_t            req_i,
  input  logic                 rsp_valid_i,
  input  scbp_rsp_t            rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   outstanding_o
);

  logic [IDX_W-1:0] free_list [NUM_CLASSES][BUFS_PER_CLASS];
  int unsigned      free_count [NUM_CLASSES];
  bit               in_use [NUM_CLASSES][BUFS_PER_CLASS];
  logic [CFG_W-1:0] small_lim, medium_lim, large_lim;

  scbp_rsp_t awaited_rsp_q[$];
  scbp_rsp_t oldest_rsp;

  task automatic refill_pool();
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      free_count[c] = BUFS_PER_CLASS;
      for (int unsigned i = 0; i < BUFS_PER_CLASS; i++) begin
        free_list[c][i] = IDX_W'(i);
        in_use[c][i]    = 1'b0;
      end
    end
    small_lim  = SMALL_LIMIT_RST;
    medium_lim = MEDIUM_LIMIT_RST;
    large_lim  = LARGE_LIMIT_RST;
  endtask

  // limits are checked top down, so unordered limits still give one class
  function automatic logic [CLS_W-1:0] class_for_size(input logic [SIZE_W-1:0] sz);
    if (sz > large_lim)  return CLS_SUPER;
    if (sz > medium_lim) return CLS_LARGE;
    if (sz > small_lim)  return CLS_MEDIUM;
    return CLS_SMALL;
  endfunction

  // applies one request to the pool and returns the result it should give
  function automatic scbp_rsp_t serve_request(input scbp_req_t r);
    scbp_rsp_t   res;
    int unsigned c;
    res.status        = ST_OK;
    res.granted_index = '0;
    if (r.action == ACT_ALLOC) begin
      res.granted_class = class_for_size(r.request_size);
      c = res.granted_class;
      if (free_count[c] == 0) begin
        res.status = ST_EXHAUSTED;
      end else begin
        free_count[c]--;
        res.granted_index = free_list[c][free_count[c]];
        in_use[c][res.granted_index] = 1'b1;
      end
    end else begin
      res.granted_class = r.release_class;
      c = r.release_class;
      if (r.release_index >= BUFS_PER_CLASS || !in_use[c][r.release_index] ||
          free_count[c] >= BUFS_PER_CLASS) begin
        res.status = ST_NOT_IN_USE;
      end else begin
        in_use[c][r.release_index] = 1'b0;
        free_list[c][free_count[c]] = r.release_index;
        free_count[c]++;
        res.granted_index = r.release_index;
      end
    end
    res.class_in_use = USE_W'(BUFS_PER_CLASS - free_count[c]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_pool();
      awaited_rsp_q.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      if (rsp_valid_i) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("result with no transaction outstanding: %p", rsp_i);
          mismatch_count_o++;
        end else begin
          oldest_rsp = awaited_rsp_q.pop_front();
          if (rsp_i.status !== oldest_rsp.status) begin
            $error("status: expected %0d, got %0d", oldest_rsp.status, rsp_i.status);
            mismatch_count_o++;
          end
          if (rsp_i.granted_class !== oldest_rsp.granted_class) begin
            $error("granted_class: expected %0d, got %0d",
                   oldest_rsp.granted_class, rsp_i.granted_class);
            mismatch_count_o++;
          end
          if (rsp_i.granted_index !== oldest_rsp.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   oldest_rsp.granted_index, rsp_i.granted_index);
            mismatch_count_o++;
          end
          if (rsp_i.class_in_use !== oldest_rsp.class_in_use) begin
            $error("class_in_use: expected %0d, got %0d",
                   oldest_rsp.class_in_use, rsp_i.class_in_use);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SMALL_LIMIT:  small_lim  = cfg_data_i;
          CFG_MEDIUM_LIMIT: medium_lim = cfg_data_i;
          CFG_LARGE_LIMIT:  large_lim  = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        awaited_rsp_q.push_back(serve_request(req_i));
      end
      outstanding_o = awaited_rsp_q.size();
    end
  end

endmodule

@@ tb/tb_size_class_buffer_pool.sv @@
// testbench top for the size class buffer pool: stimulus, checker hookup and verdict
`timescale 1ns / 100ps

module tb_size_class_buffer_pool;
  import scbp_pkg::*;

  localparam int unsigned BUFS_PER_CLASS = 1024;
  // the fourth register slot has no register behind it, writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
  } handle_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 start;
  logic                 busy;
  scbp_req_t            req;
  logic                 rsp_valid;
  scbp_rsp_t            rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int mismatch_count;
  int outstanding;

  // stimulus side bookkeeping: buffers believed to be held, used to build legal frees
  handle_t    live_handles[$];
  handle_t    last_freed;
  logic       issued_actions[$];
  logic       done_action;
  logic [CFG_W-1:0] cur_limit [3];
  int         calm_left;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  size_class_buffer_pool #(
    .BUFS_PER_CLASS(BUFS_PER_CLASS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  pool_checker #(
    .BUFS_PER_CLASS(BUFS_PER_CLASS)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .req_i           (req),
    .rsp_valid_i     (rsp_valid),
    .rsp_i           (rsp),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // harvest granted buffers so later frees can name them
  always @(posedge clk) begin
    if (rst_n && rsp_valid && issued_actions.size() != 0) begin
      done_action = issued_actions.pop_front();
      if (done_action == ACT_ALLOC && rsp.status == ST_OK) begin
        live_handles.push_back({rsp.granted_class, rsp.granted_index});
      end
    end
  end

  // idle gap before the next transaction: mostly 0..19, with bursts of none
  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // called and returns just after a falling edge; start stays high on return
  task automatic send_request(input scbp_req_t r);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    issued_actions.push_back(r.action);
    @(negedge clk);
  endtask

  // wait until every result is back, then let the pipeline drain
  task automatic wait_idle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_data  = CFG_W'($urandom);
  endtask

  function automatic scbp_req_t make_alloc(input logic [SIZE_W-1:0] sz);
    scbp_req_t r;
    r = scbp_req_t'($urandom);
    r.action       = ACT_ALLOC;
    r.request_size = sz;
    return r;
  endfunction

  function automatic scbp_req_t make_free(input logic [CLS_W-1:0] c, input logic [IDX_W-1:0] i);
    scbp_req_t r;
    r = scbp_req_t'($urandom);
    r.action        = ACT_FREE;
    r.release_class = c;
    r.release_index = i;
    return r;
  endfunction

  // sizes cluster around the class limits so each boundary is hit from both sides
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return SIZE_W'($urandom);
      1:       return cur_limit[$urandom_range(0, 2)] + SIZE_W'($urandom_range(0, 2)) - 1'b1;
      default: return SIZE_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic scbp_req_t random_request(input int alloc_pct);
    scbp_req_t r;
    handle_t   h;
    int        roll, k;
    if ($urandom_range(0, 99) < alloc_pct) return make_alloc(pick_size());
    roll = $urandom_range(0, 99);
    if (roll < 80 && live_handles.size() != 0) begin
      // legal free of a held buffer
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      live_handles.delete(k);
      last_freed = h;
      r = make_free(h.cls, h.idx);
    end else if (roll < 90) begin
      // most likely a double free
      r = make_free(last_freed.cls, last_freed.idx);
    end else begin
      // noise: any class, any index
      r = make_free(CLS_W'($urandom), IDX_W'($urandom));
    end
    r.request_size = SIZE_W'($urandom);
    return r;
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] sml, input logic [CFG_W-1:0] med,
                           input logic [CFG_W-1:0] lrg, input int alloc_pct, input int count);
    wait_idle();
    write_register(CFG_SMALL_LIMIT, sml);
    write_register(CFG_MEDIUM_LIMIT, med);
    write_register(CFG_LARGE_LIMIT, lrg);
    cur_limit[0] = sml;
    cur_limit[1] = med;
    cur_limit[2] = lrg;
    for (int n = 0; n < count; n++) begin
      // now and then hold off until the pool has answered everything
      if ($urandom_range(0, 199) == 0) wait_idle();
      send_request(random_request(alloc_pct));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SMALL_LIMIT;
    cfg_data   = '0;
    calm_left  = 0;
    last_freed = '0;
    cur_limit[0] = SMALL_LIMIT_RST;
    cur_limit[1] = MEDIUM_LIMIT_RST;
    cur_limit[2] = LARGE_LIMIT_RST;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset limits, every class boundary, both ends of the size range
    send_request(make_alloc(16'd0));
    send_request(make_alloc(16'd64));
    send_request(make_alloc(16'd65));
    send_request(make_alloc(16'd128));
    send_request(make_alloc(16'd129));
    send_request(make_alloc(16'd256));
    send_request(make_alloc(16'd257));
    send_request(make_alloc(16'hFFFF));
    // good free, then the same buffer again, then one never handed out
    send_request(make_free(CLS_SMALL, 10'd1023));
    send_request(make_free(CLS_SMALL, 10'd1023));
    send_request(make_free(CLS_SMALL, 10'd0));
    send_request(make_free(CLS_MEDIUM, 10'd1023));
    send_request(make_free(CLS_LARGE, 10'd0));
    send_request(make_free(CLS_SUPER, 10'd1023));
    send_request(make_free(CLS_SUPER, 10'd1022));
    send_request(make_free(CLS_SUPER, 10'd1022));
    // freed index comes back first from the stack
    send_request(make_alloc(16'd0));
    send_request(make_free(CLS_LARGE, 10'd1023));
    send_request(make_free(CLS_LARGE, 10'd1022));
    send_request(make_free(CLS_MEDIUM, 10'd1022));
    send_request(make_free(CLS_SMALL, 10'd1022));

    // random phases: reset-like limits, all-small extremes to exhaust class 0,
    // minimum limits while draining, then limits out of order
    run_phase(SMALL_LIMIT_RST, MEDIUM_LIMIT_RST, LARGE_LIMIT_RST, 60, 250);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 97, 1200);
    run_phase(16'd1, 16'd1, 16'd1, 30, 300);
    wait_idle();
    write_register(CFG_UNUSED, 16'd7);
    run_phase(16'd300, 16'd200, 16'd100, 50, 300);

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
